// ===== rtl/time_of_day_ms_arithmetic_macros.svh =====
// assertion macros for the time-of-day block checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TIME_OF_DAY_MS_ARITHMETIC_MACROS_SVH
`define TIME_OF_DAY_MS_ARITHMETIC_MACROS_SVH

// property sampled on clk, off while reset is low
`define TOD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TOD_ASSERT_NEXT(lbl, ante, cons, msg) \
    `TOD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/tod_pkg.sv =====
// shared types and constants of the time-of-day block
// used by tod_ctrl, tod_dp, the top level and the checker; no dependencies
package tod_pkg;

    // request and response beats
    typedef struct packed {
        logic               opcode;
        logic [3:0]         field_mask;
        logic [4:0]         new_hour;
        logic [5:0]         new_minute;
        logic [5:0]         new_second;
        logic [9:0]         new_millisecond;
        logic signed [31:0] delta_seconds;
    } req_beat_t;

    typedef struct packed {
        logic [4:0]         hour_out;
        logic [5:0]         minute_out;
        logic [5:0]         second_out;
        logic [9:0]         millisecond_out;
        logic signed [15:0] day_carry;
        logic               invalid;
    } rsp_beat_t;

    // opcodes
    localparam logic OPC_SET = 1'b0;
    localparam logic OPC_ADD = 1'b1;

    // field mask bits
    localparam int MASK_HOUR   = 0;
    localparam int MASK_MINUTE = 1;
    localparam int MASK_SECOND = 2;
    localparam int MASK_MSEC   = 3;

    // field limits
    localparam logic [4:0] MAX_HOUR   = 5'd23;
    localparam logic [5:0] MAX_MINUTE = 6'd59;
    localparam logic [5:0] MAX_SECOND = 6'd59;
    localparam logic [9:0] MAX_MSEC   = 10'd999;

    // time constants
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

    // seconds per day = 675 * 128, so the day split is a shift then a divide by 675
    localparam logic [9:0]  DAY_ODD      = 10'd675;
    localparam int          DAY_SHIFT    = 7;

    // bias that makes the delta non-negative: CARRY_BIAS whole days
    localparam logic [15:0] CARRY_BIAS   = 16'd24856;
    localparam logic [32:0] DAY_OFFSET   = 33'(64'd24856 * 64'd86400);

    // reciprocals, floor(2^k / d); the estimate is low by at most one
    localparam int          Q_SHIFT      = 36;
    localparam logic [26:0] RECIP_675    = 27'((64'd1 << Q_SHIFT) / 64'd675);
    localparam int          H_SHIFT      = 22;
    localparam logic [10:0] RECIP_3600   = 11'((64'd1 << H_SHIFT) / 64'd3600);
    localparam int          M_SHIFT      = 16;
    localparam logic [10:0] RECIP_60     = 11'((64'd1 << M_SHIFT) / 64'd60);

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EST_Q,
        ST_FIX_Q,
        ST_WRAP,
        ST_EST_H,
        ST_FIX_H,
        ST_EST_M,
        ST_FIX_M,
        ST_FINISH
    } tod_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic est_q;
        logic fix_q;
        logic wrap;
        logic est_h;
        logic fix_h;
        logic est_m;
        logic fix_m;
        logic commit;
    } dp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/tod_dp.sv =====
// datapath of the time-of-day block: time registers, divide steps, response register
// depends on tod_pkg; sequenced by tod_ctrl
module tod_dp
    import tod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_beat_t  req,
    input  logic       rsp_ready,
    input  dp_ctrl_t   ctrl,
    output dp_status_t status,
    output logic       rsp_valid,
    output rsp_beat_t  rsp
);

    // held time of day, kept as fields
    logic [4:0] hour_reg;
    logic [5:0] minute_reg;
    logic [5:0] second_reg;
    logic [9:0] msec_reg;

    // working registers
    req_beat_t          op_reg;
    logic [16:0]        q_reg;
    logic [9:0]         r_reg;
    logic [16:0]        sod_reg;
    logic [16:0]        nsec_reg;
    logic signed [15:0] carry_reg;
    logic [4:0]         hq_reg;
    logic [11:0]        hrem_reg;
    logic [5:0]         mq_reg;
    logic [5:0]         sec_res_reg;

    // response stage
    rsp_beat_t rsp_reg;
    logic      rsp_valid_reg;

    // next values
    logic [32:0]        biased;
    logic [25:0]        v_hi;
    logic [6:0]         v_lo;
    logic [52:0]        q_prod;
    logic [16:0]        q_next;
    logic [16:0]        sod_next;
    logic [26:0]        q_back;
    logic [26:0]        q_rem;
    logic [9:0]         r_next;
    logic [16:0]        q_fix_next;
    logic [16:0]        rd;
    logic [17:0]        sec_sum;
    logic               day_wrap;
    logic [16:0]        nsec_next;
    logic signed [15:0] carry_next;
    logic [27:0]        h_prod;
    logic [4:0]         hq_next;
    logic [16:0]        h_back;
    logic [16:0]        h_rem;
    logic [4:0]         hq_fix_next;
    logic [11:0]        hrem_next;
    logic [22:0]        m_prod;
    logic [5:0]         mq_next;
    logic [11:0]        m_back;
    logic [11:0]        m_rem;
    logic [5:0]         mq_fix_next;
    logic [5:0]         sec_res_next;
    logic [4:0]         set_hour;
    logic [5:0]         set_minute;
    logic [5:0]         set_second;
    logic [9:0]         set_msec;
    logic               set_bad;
    logic [4:0]         fin_hour;
    logic [5:0]         fin_minute;
    logic [5:0]         fin_second;
    logic [9:0]         fin_msec;
    rsp_beat_t          rsp_next;

    // biased delta split into 675-part and 128-part
    assign biased = {op_reg.delta_seconds[31], op_reg.delta_seconds} + DAY_OFFSET;
    assign v_hi   = biased[32:DAY_SHIFT];
    assign v_lo   = biased[DAY_SHIFT-1:0];

    // quotient estimate and seconds of day
    assign q_prod   = 53'(v_hi) * 53'(RECIP_675);
    assign q_next   = q_prod[Q_SHIFT+16:Q_SHIFT];
    assign sod_next = 17'(hour_reg) * 17'(SEC_PER_HOUR)
                    + 17'(minute_reg) * 17'(SEC_PER_MIN)
                    + 17'(second_reg);

    // quotient correction by one
    assign q_back = 27'(q_reg) * 27'(DAY_ODD);
    assign q_rem  = 27'(v_hi) - q_back;
    always_comb
    begin
        if (q_rem >= 27'(DAY_ODD))
        begin
            q_fix_next = q_reg + 17'd1;
            r_next     = 10'(q_rem - 27'(DAY_ODD));
        end
        else
        begin
            q_fix_next = q_reg;
            r_next     = 10'(q_rem);
        end
    end

    // add the sub-day remainder and wrap into one day
    assign rd       = {r_reg, v_lo};
    assign sec_sum  = 18'(sod_reg) + 18'(rd);
    assign day_wrap = (sec_sum >= 18'(SEC_PER_DAY));
    assign nsec_next = day_wrap ? 17'(sec_sum - 18'(SEC_PER_DAY)) : 17'(sec_sum);
    assign carry_next = 16'(18'(q_reg) + 18'(day_wrap) - 18'(CARRY_BIAS));

    // hour estimate and correction
    assign h_prod  = 28'(nsec_reg) * 28'(RECIP_3600);
    assign hq_next = h_prod[H_SHIFT+4:H_SHIFT];
    assign h_back  = 17'(hq_reg) * 17'(SEC_PER_HOUR);
    assign h_rem   = nsec_reg - h_back;
    always_comb
    begin
        if (h_rem >= 17'(SEC_PER_HOUR))
        begin
            hq_fix_next = hq_reg + 5'd1;
            hrem_next   = 12'(h_rem - 17'(SEC_PER_HOUR));
        end
        else
        begin
            hq_fix_next = hq_reg;
            hrem_next   = 12'(h_rem);
        end
    end

    // minute estimate and correction
    assign m_prod  = 23'(hrem_reg) * 23'(RECIP_60);
    assign mq_next = m_prod[M_SHIFT+5:M_SHIFT];
    assign m_back  = 12'(mq_reg) * 12'(SEC_PER_MIN);
    assign m_rem   = hrem_reg - m_back;
    always_comb
    begin
        if (m_rem >= 12'(SEC_PER_MIN))
        begin
            mq_fix_next  = mq_reg + 6'd1;
            sec_res_next = 6'(m_rem - 12'(SEC_PER_MIN));
        end
        else
        begin
            mq_fix_next  = mq_reg;
            sec_res_next = 6'(m_rem);
        end
    end

    // set: merge masked fields and range check
    always_comb
    begin
        set_hour   = op_reg.field_mask[MASK_HOUR]   ? op_reg.new_hour        : hour_reg;
        set_minute = op_reg.field_mask[MASK_MINUTE] ? op_reg.new_minute      : minute_reg;
        set_second = op_reg.field_mask[MASK_SECOND] ? op_reg.new_second      : second_reg;
        set_msec   = op_reg.field_mask[MASK_MSEC]   ? op_reg.new_millisecond : msec_reg;
        set_bad    = (set_hour > MAX_HOUR) || (set_minute > MAX_MINUTE)
                  || (set_second > MAX_SECOND) || (set_msec > MAX_MSEC);
    end

    // final time and response
    always_comb
    begin
        if (op_reg.opcode == OPC_ADD)
        begin
            fin_hour   = hq_reg;
            fin_minute = mq_reg;
            fin_second = sec_res_reg;
            fin_msec   = msec_reg;
        end
        else if (set_bad)
        begin
            fin_hour   = hour_reg;
            fin_minute = minute_reg;
            fin_second = second_reg;
            fin_msec   = msec_reg;
        end
        else
        begin
            fin_hour   = set_hour;
            fin_minute = set_minute;
            fin_second = set_second;
            fin_msec   = set_msec;
        end
        rsp_next.hour_out        = fin_hour;
        rsp_next.minute_out      = fin_minute;
        rsp_next.second_out      = fin_second;
        rsp_next.millisecond_out = fin_msec;
        rsp_next.day_carry       = (op_reg.opcode == OPC_ADD) ? carry_reg : 16'sd0;
        rsp_next.invalid         = (op_reg.opcode == OPC_SET) && set_bad;
    end

    // time of day state, midnight after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            msec_reg   <= '0;
        end
        else if (ctrl.commit)
        begin
            hour_reg   <= fin_hour;
            minute_reg <= fin_minute;
            second_reg <= fin_second;
            msec_reg   <= fin_msec;
        end
    end

    // working registers, one step per command
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg <= req;
        end
        if (ctrl.est_q)
        begin
            q_reg   <= q_next;
            sod_reg <= sod_next;
        end
        if (ctrl.fix_q)
        begin
            q_reg <= q_fix_next;
            r_reg <= r_next;
        end
        if (ctrl.wrap)
        begin
            nsec_reg  <= nsec_next;
            carry_reg <= carry_next;
        end
        if (ctrl.est_h)
        begin
            hq_reg <= hq_next;
        end
        if (ctrl.fix_h)
        begin
            hq_reg   <= hq_fix_next;
            hrem_reg <= hrem_next;
        end
        if (ctrl.est_m)
        begin
            mq_reg <= mq_next;
        end
        if (ctrl.fix_m)
        begin
            mq_reg      <= mq_fix_next;
            sec_res_reg <= sec_res_next;
        end
        if (ctrl.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

endmodule

// ===== rtl/tod_ctrl.sv =====
// controller of the time-of-day block: sequences the datapath steps
// depends on tod_pkg; drives tod_dp through dp_ctrl_t
module tod_ctrl
    import tod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_opcode,
    input  dp_status_t status,
    output logic       req_ready,
    output dp_ctrl_t   ctrl
);

    tod_state_t state_reg;
    tod_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_opcode == OPC_ADD) ? ST_EST_Q : ST_FINISH;
                end
            end
            ST_EST_Q: state_next = ST_FIX_Q;
            ST_FIX_Q: state_next = ST_WRAP;
            ST_WRAP:  state_next = ST_EST_H;
            ST_EST_H: state_next = ST_FIX_H;
            ST_FIX_H: state_next = ST_EST_M;
            ST_EST_M: state_next = ST_FIX_M;
            ST_FIX_M: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        ctrl      = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                ctrl.load = req_valid;
            end
            ST_EST_Q:  ctrl.est_q  = 1'b1;
            ST_FIX_Q:  ctrl.fix_q  = 1'b1;
            ST_WRAP:   ctrl.wrap   = 1'b1;
            ST_EST_H:  ctrl.est_h  = 1'b1;
            ST_FIX_H:  ctrl.fix_h  = 1'b1;
            ST_EST_M:  ctrl.est_m  = 1'b1;
            ST_FIX_M:  ctrl.fix_m  = 1'b1;
            ST_FINISH: ctrl.commit = status.out_free;
            default:   ctrl        = '0;
        endcase
    end

endmodule

// ===== rtl/time_of_day_ms_arithmetic.sv =====
// add beat: after acceptance, the seven steps of the constant-divide sequence
// (day, hour, minute), then a finish step that writes the response register
// set beat: straight to the finish step; one request in work at a time
// the next request is taken while a finished response still waits in its register;
// a finished item then waits in its last step until that register frees up
// reset (rst_n low, asynchronous) sets the time to midnight and empties the response
module time_of_day_ms_arithmetic
    import tod_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_beat_t rsp
);

    dp_ctrl_t   ctrl;
    dp_status_t status;

    // step sequencer
    tod_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .status     (status),
        .req_ready  (req_ready),
        .ctrl       (ctrl)
    );

    // time registers and arithmetic
    tod_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/tod_checker.sv =====
// port-level checker for the time-of-day block, bound to the top level
// depends on tod_pkg and time_of_day_ms_arithmetic_macros.svh
`include "time_of_day_ms_arithmetic_macros.svh"

module tod_checker
    import tod_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input req_beat_t req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_beat_t rsp
);

    logic rsp_stalled;
    logic rsp_time_legal;
    logic rsp_rejected;
    logic rsp_carry_zero;

    // response beat conditions
    assign rsp_stalled    = rsp_valid && !rsp_ready;
    assign rsp_time_legal = (rsp.hour_out <= MAX_HOUR) && (rsp.minute_out <= MAX_MINUTE)
                         && (rsp.second_out <= MAX_SECOND)
                         && (rsp.millisecond_out <= MAX_MSEC);
    assign rsp_rejected   = rsp_valid && rsp.invalid;
    assign rsp_carry_zero = (rsp.day_carry == 16'sd0);

    // a waiting response beat holds
    `TOD_ASSERT_NEXT(a_rsp_hold, rsp_stalled, rsp_valid && $stable(rsp), "rsp beat not held")

    // reported time is always a legal time of day
    `TOD_ASSERT(a_rsp_range, rsp_valid |-> rsp_time_legal, "rsp time out of range")

    // a rejected set carries no day count
    `TOD_ASSERT(a_invalid_no_carry, rsp_rejected |-> rsp_carry_zero, "invalid beat with day carry")

    // one item in work at a time
    `TOD_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready, "req taken back to back")

endmodule

bind time_of_day_ms_arithmetic tod_checker u_tod_checker (.*);
